// File: hdl/tsc_pkg.sv
// Shared types, constants and classification functions of the token stream classifier.
package tsc_pkg;

    localparam int TOKEN_MAX     = 127;
    localparam int POSITION_BITS = 16;

    // Widths of the fields of one result transaction.
    localparam int KIND_W  = 2;
    localparam int WHICH_W = 5;
    localparam int START_W = 16;
    localparam int LEN_W   = $clog2(TOKEN_MAX + 1);
    // The word length counter stops at TOKEN_MAX + 1.
    localparam int CNT_W   = $clog2(TOKEN_MAX + 2);

    localparam int NUM_SINGLES = 12;
    localparam int NUM_PAIRS   = 7;
    localparam int NUM_KW      = 5;
    localparam int KW_CHARS    = 6;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_OPERATOR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEYWORD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDENTIFIER = 2'd3;

    localparam logic [WHICH_W-1:0] PAIR_BASE = 5'd12;

    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [7:0] OPERATOR_BYTES [NUM_SINGLES] = '{
        8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h3b,
        8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3e, 8'h3c
    };

    localparam logic [7:0] PAIR_FIRST [NUM_PAIRS] = '{
        8'h3d, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3e, 8'h3c
    };

    // Keywords: int, if, while, return, main.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
        '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
        '{8'h6d, 8'h61, 8'h69, 8'h6e, 8'h00, 8'h00}
    };

    localparam logic [CNT_W-1:0] KW_LEN [NUM_KW] = '{
        CNT_W'(3), CNT_W'(2), CNT_W'(5), CNT_W'(6), CNT_W'(4)
    };

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WHICH_W-1:0] which;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               truncated;
    } tok_t;

    // One queue entry holds every token that one input byte produced.
    typedef struct packed {
        tok_t t0;
        tok_t t1;
        logic two;
    } entry_t;

    typedef struct packed {
        logic                 hit;
        logic [WHICH_W-1:0]   code;
    } op_hit_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h00) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic op_hit_t single_lookup(input logic [7:0] c);
        op_hit_t r;
        r.hit  = 1'b0;
        r.code = '0;
        for (int i = NUM_SINGLES - 1; i >= 0; i--) begin
            if (OPERATOR_BYTES[i] == c) begin
                r.hit  = 1'b1;
                r.code = WHICH_W'(i);
            end
        end
        return r;
    endfunction

    function automatic op_hit_t pair_lookup(input logic [7:0] a, input logic [7:0] b);
        op_hit_t r;
        r.hit  = 1'b0;
        r.code = '0;
        for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
            if ((b == CH_EQUAL) && (PAIR_FIRST[i] == a)) begin
                r.hit  = 1'b1;
                r.code = PAIR_BASE + WHICH_W'(i);
            end
        end
        return r;
    endfunction

    // Bit i stays set if keyword i still matches with byte c at offset k.
    function automatic logic [NUM_KW-1:0] kw_match(input logic [CNT_W-1:0] k,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (k < KW_LEN[i]) begin
                m[i] = (KW_TEXT[i][k[2:0]] == c);
            end
        end
        return m;
    endfunction

    function automatic logic [START_W-1:0] to_start(input logic [POSITION_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[START_W-1:0];
    endfunction

    function automatic tok_t make_op(input logic [WHICH_W-1:0] code,
                                     input logic [POSITION_BITS-1:0] start,
                                     input logic [LEN_W-1:0] len);
        tok_t t;
        t.kind      = KIND_OPERATOR;
        t.which     = code;
        t.start     = to_start(start);
        t.length    = len;
        t.truncated = 1'b0;
        return t;
    endfunction

    function automatic tok_t make_word(input logic [NUM_KW-1:0] alive,
                                       input logic [CNT_W-1:0] tlen,
                                       input logic digits,
                                       input logic [POSITION_BITS-1:0] start);
        tok_t t;
        t.kind  = digits ? KIND_NUMBER : KIND_IDENTIFIER;
        t.which = '0;
        // The lowest keyword index wins, so scan from the top down.
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (alive[i] && (tlen == KW_LEN[i])) begin
                t.kind  = KIND_KEYWORD;
                t.which = WHICH_W'(i);
            end
        end
        t.start     = to_start(start);
        t.truncated = (tlen > CNT_W'(TOKEN_MAX));
        t.length    = t.truncated ? LEN_W'(TOKEN_MAX) : tlen[LEN_W-1:0];
        return t;
    endfunction

endpackage

// File: hdl/tsc_front.sv
// Front end: accepts source bytes, tracks lexer state and builds the tokens of each byte.
module tsc_front import tsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_text,
    input  logic        q_full,
    output logic        push_valid,
    output entry_t      push_data
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_HELD,
        MODE_COMMENT
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [7:0]               held_reg, held_next;
    logic [NUM_KW-1:0]        alive_reg, alive_next;
    logic                     digits_reg, digits_next;
    logic [CNT_W-1:0]         tlen_reg, tlen_next;
    logic [POSITION_BITS-1:0] tstart_reg, tstart_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic    in_fire;
    logic    fresh;
    logic    v0, v1;
    tok_t    t0, t1, tw;
    op_hit_t c_single, held_single, pair;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    assign c_single    = single_lookup(s_ch);
    assign held_single = single_lookup(held_reg);
    assign pair        = pair_lookup(held_reg, s_ch);

    always_comb begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        alive_next  = alive_reg;
        digits_next = digits_reg;
        tlen_next   = tlen_reg;
        tstart_next = tstart_reg;
        pos_next    = pos_reg + POSITION_BITS'(1);
        fresh       = 1'b0;
        v0          = 1'b0;
        v1          = 1'b0;
        t0          = '0;
        t1          = '0;
        tw          = '0;

        case (mode_reg)
            MODE_COMMENT: begin
                if (s_ch == CH_NEWLINE) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_HELD: begin
                if ((held_reg == CH_SLASH) && (s_ch == CH_SLASH)) begin
                    mode_next = MODE_COMMENT;
                end else if (pair.hit) begin
                    t0        = make_op(pair.code, tstart_reg, LEN_W'(2));
                    v0        = 1'b1;
                    mode_next = MODE_IDLE;
                end else begin
                    t0    = make_op(held_single.code, tstart_reg, LEN_W'(1));
                    v0    = 1'b1;
                    fresh = 1'b1;
                end
            end
            MODE_WORD: begin
                if (is_space(s_ch) || c_single.hit) begin
                    t0    = make_word(alive_reg, tlen_reg, digits_reg, tstart_reg);
                    v0    = 1'b1;
                    fresh = 1'b1;
                end else begin
                    alive_next  = alive_reg & kw_match(tlen_reg, s_ch);
                    digits_next = digits_reg & is_digit(s_ch);
                    if (tlen_reg <= CNT_W'(TOKEN_MAX)) begin
                        tlen_next = tlen_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // A byte that closes a token may open the next one.
        if (fresh) begin
            if (is_space(s_ch)) begin
                mode_next = MODE_IDLE;
            end else if (c_single.hit) begin
                mode_next   = MODE_HELD;
                held_next   = s_ch;
                tstart_next = pos_reg;
            end else begin
                mode_next   = MODE_WORD;
                tstart_next = pos_reg;
                alive_next  = kw_match('0, s_ch);
                digits_next = is_digit(s_ch);
                tlen_next   = CNT_W'(1);
            end
        end

        // End of text flushes whatever is pending and restarts at position zero.
        if (s_end_of_text) begin
            if (mode_next == MODE_HELD) begin
                tw = make_op(single_lookup(held_next).code, tstart_next, LEN_W'(1));
            end else begin
                tw = make_word(alive_next, tlen_next, digits_next, tstart_next);
            end
            if ((mode_next == MODE_HELD) || (mode_next == MODE_WORD)) begin
                if (v0) begin
                    t1 = tw;
                    v1 = 1'b1;
                end else begin
                    t0 = tw;
                    v0 = 1'b1;
                end
            end
            mode_next   = MODE_IDLE;
            held_next   = '0;
            alive_next  = '1;
            digits_next = 1'b1;
            tlen_next   = '0;
            tstart_next = '0;
            pos_next    = '0;
        end
    end

    assign push_valid    = in_fire && v0;
    assign push_data.t0  = t0;
    assign push_data.t1  = t1;
    assign push_data.two = v1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= '0;
            alive_reg  <= '1;
            digits_reg <= 1'b1;
            tlen_reg   <= '0;
            tstart_reg <= '0;
            pos_reg    <= '0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            alive_reg  <= alive_next;
            digits_reg <= digits_next;
            tlen_reg   <= tlen_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// File: hdl/tsc_queue.sv
// Short token queue between the front end and the output stage.
module tsc_queue import tsc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop_ready,
    output logic   pop_valid,
    output entry_t pop_data
);

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 push_fire, pop_fire;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign push_fire = push_valid && !full;
    assign pop_fire  = pop_ready && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("token queue count exceeds its depth");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !full)
        else $error("token entry offered while the queue is full");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> pop_valid)
        else $error("queue empty right after a push");

endmodule

// File: hdl/tsc_back.sv
// Output stage: takes queue entries and hands their tokens out one transaction at a time.
module tsc_back import tsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  entry_t             q_data,
    output logic               q_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [WHICH_W-1:0] m_which,
    output logic [START_W-1:0] m_start_res,
    output logic [LEN_W-1:0]   m_length,
    output logic               m_truncated,
    output logic               m_last
);

    entry_t cur_reg;
    logic   cur_valid_reg;
    logic   sel_reg;
    logic   advance;
    tok_t   tok;

    assign tok         = sel_reg ? cur_reg.t1 : cur_reg.t0;
    assign m_valid     = cur_valid_reg;
    assign m_kind      = tok.kind;
    assign m_which     = tok.which;
    assign m_start_res = tok.start;
    assign m_length    = tok.length;
    assign m_truncated = tok.truncated;
    assign m_last      = sel_reg || !cur_reg.two;
    assign advance     = m_valid && m_ready;
    // The holding register refills in the same cycle its final token leaves.
    assign q_ready     = !cur_valid_reg || (advance && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end else if (q_ready) begin
            cur_valid_reg <= q_valid;
            sel_reg       <= 1'b0;
        end else if (advance) begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            cur_reg <= q_data;
        end
    end

    a_second_only_of_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (cur_valid_reg && cur_reg.two))
        else $error("second token selected from a single-token entry");

endmodule

// File: hdl/token_stream_classifier.sv
// Top level of the token stream classifier: front end, token queue and output stage.
//
// Source text enters one byte per transaction on the s_ channel (s_ch, with
// s_end_of_text on the final byte of a text). White space and line comments
// are dropped; every finished token leaves as one m_ transaction carrying its
// kind, code, start position, saturated length and truncation flag. m_last
// marks the final token produced by a given input byte; a byte yields zero,
// one or two tokens.
// A token that a byte completes is written into the queue when the byte is
// accepted, then loaded from the queue into the output register and presented on m_.
// Throughput: one byte per cycle while the queue is not full; the output side
// moves one token per cycle while m_ready is high, so a byte that finishes two
// tokens keeps the output side busy for both, absorbed by the four-entry queue.
// When the receiver stalls, tokens collect in the queue and s_ready drops only
// once the queue is full; no token is lost or reordered.
// Reset (aresetn low, synchronous) empties the queue and output stage and
// returns the lexer to idle at position zero. After end of text the lexer
// likewise restarts at position zero.
module token_stream_classifier import tsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ch,
    input  logic               s_end_of_text,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [WHICH_W-1:0] m_which,
    output logic [START_W-1:0] m_start_res,
    output logic [LEN_W-1:0]   m_length,
    output logic               m_truncated,
    output logic               m_last
);

    logic   push_valid;
    entry_t push_data;
    logic   q_full;
    logic   q_valid;
    logic   q_ready;
    entry_t q_data;

    tsc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    tsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop_ready  (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    tsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_ready     (q_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_which     (m_which),
        .m_start_res (m_start_res),
        .m_length    (m_length),
        .m_truncated (m_truncated),
        .m_last      (m_last)
    );

endmodule
